[src/sccrz_pkg.sv]
// Shared types, constants and helpers for the RZ spectral current correction block
`default_nettype none
package sccrz_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int INV_W     = 31;
    localparam int PROD_W    = 64;
    localparam int NUM_W     = 50;
    localparam int DEN_W     = 64;
    localparam int Q_BITS    = 32;
    localparam int SUM_W     = 50;
    localparam int NUM_STAGES = 2;
    localparam int UPD_STAGES = 2;
    localparam int LATENCY   = NUM_STAGES + Q_BITS + 2 + UPD_STAGES;

    localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        data_t jplus_re;
        data_t jplus_im;
        data_t jminus_re;
        data_t jminus_im;
        data_t jaxial_re;
        data_t jaxial_im;
        data_t charge_old_re;
        data_t charge_old_im;
        data_t charge_new_re;
        data_t charge_new_im;
        data_t radial_wavenumber;
        data_t axial_wavenumber;
    } in_item_t;

    typedef struct packed {
        data_t out_jplus_re;
        data_t out_jplus_im;
        data_t out_jminus_re;
        data_t out_jminus_im;
        data_t out_jaxial_re;
        data_t out_jaxial_im;
    } out_item_t;

    // currents and wavenumbers carried alongside the quotient
    typedef struct packed {
        data_t jp_re;
        data_t jp_im;
        data_t jm_re;
        data_t jm_im;
        data_t jz_re;
        data_t jz_im;
        data_t kr;
        data_t kz;
        logic  zero_k;
    } side_t;

    typedef struct packed {
        logic [DEN_W-1:0]   r_re;
        logic [DEN_W-1:0]   r_im;
        logic [Q_BITS-1:0]  q_re;
        logic [Q_BITS-1:0]  q_im;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
        logic [DEN_W-1:0]   d;
        side_t              side;
    } div_st_t;

    function automatic data_t sat_data(input logic signed [SUM_W-1:0] x);
        data_t y;
        if (x > SUM_W'(DATA_MAX))
            y = DATA_MAX;
        else if (x < SUM_W'(DATA_MIN))
            y = DATA_MIN;
        else
            y = x[DATA_W-1:0];
        return y;
    endfunction

endpackage
`default_nettype wire

[src/sccrz_numer.sv]
// Numerator products and sums, denominator kr^2 + kz^2
`default_nettype none
module sccrz_numer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire sccrz_pkg::in_item_t           in_item,
    input  wire logic [sccrz_pkg::INV_W-1:0]   inv_dt,
    output logic                               out_valid,
    output logic signed [sccrz_pkg::NUM_W-1:0] n_re,
    output logic signed [sccrz_pkg::NUM_W-1:0] n_im,
    output logic [sccrz_pkg::DEN_W-1:0]        k2,
    output sccrz_pkg::side_t                   side
);
    import sccrz_pkg::*;

    logic signed [DATA_W:0]   drho_re, drho_im, dj_re, dj_im;
    logic signed [DATA_W:0]   inv_s;
    logic signed [PROD_W:0]   p_rho_re_w, p_rho_im_w, p_kr_re_w, p_kr_im_w;
    logic signed [PROD_W-1:0] p_rho_re_reg, p_rho_im_reg, p_kr_re_reg, p_kr_im_reg;
    logic signed [PROD_W-1:0] p_kzjzim_reg, p_kzjzre_reg, kr2_reg, kz2_reg;
    side_t                    side1_reg;
    logic                     vld1_reg;

    logic signed [NUM_W-1:0]  n_re_next, n_im_next;
    logic [DEN_W-1:0]         k2_next;
    logic signed [NUM_W-1:0]  n_re_reg, n_im_reg;
    logic [DEN_W-1:0]         k2_reg;
    side_t                    side2_reg;
    logic                     vld2_reg;

    always_comb
    begin
        drho_re = (DATA_W+1)'(in_item.charge_new_re) - (DATA_W+1)'(in_item.charge_old_re);
        drho_im = (DATA_W+1)'(in_item.charge_new_im) - (DATA_W+1)'(in_item.charge_old_im);
        dj_re   = (DATA_W+1)'(in_item.jplus_re) - (DATA_W+1)'(in_item.jminus_re);
        dj_im   = (DATA_W+1)'(in_item.jplus_im) - (DATA_W+1)'(in_item.jminus_im);
        inv_s   = $signed({2'b00, inv_dt});
        p_rho_re_w = drho_re * inv_s;
        p_rho_im_w = drho_im * inv_s;
        p_kr_re_w  = (DATA_W+1)'(in_item.radial_wavenumber) * dj_re;
        p_kr_im_w  = (DATA_W+1)'(in_item.radial_wavenumber) * dj_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rho_re_reg <= p_rho_re_w[PROD_W-1:0];
        p_rho_im_reg <= p_rho_im_w[PROD_W-1:0];
        p_kr_re_reg  <= p_kr_re_w[PROD_W-1:0];
        p_kr_im_reg  <= p_kr_im_w[PROD_W-1:0];
        p_kzjzim_reg <= PROD_W'(in_item.axial_wavenumber) * PROD_W'(in_item.jaxial_im);
        p_kzjzre_reg <= PROD_W'(in_item.axial_wavenumber) * PROD_W'(in_item.jaxial_re);
        kr2_reg <= PROD_W'(in_item.radial_wavenumber) * PROD_W'(in_item.radial_wavenumber);
        kz2_reg <= PROD_W'(in_item.axial_wavenumber) * PROD_W'(in_item.axial_wavenumber);
        side1_reg.jp_re  <= in_item.jplus_re;
        side1_reg.jp_im  <= in_item.jplus_im;
        side1_reg.jm_re  <= in_item.jminus_re;
        side1_reg.jm_im  <= in_item.jminus_im;
        side1_reg.jz_re  <= in_item.jaxial_re;
        side1_reg.jz_im  <= in_item.jaxial_im;
        side1_reg.kr     <= in_item.radial_wavenumber;
        side1_reg.kz     <= in_item.axial_wavenumber;
        side1_reg.zero_k <= (in_item.radial_wavenumber == '0) &&
                            (in_item.axial_wavenumber == '0);
    end

    // drop 16 fraction bits by arithmetic shift, i.e. floor
    always_comb
    begin
        n_re_next = NUM_W'($signed(p_rho_re_reg[PROD_W-1:FRAC_BITS]))
                  - NUM_W'($signed(p_kzjzim_reg[PROD_W-1:FRAC_BITS]))
                  + NUM_W'($signed(p_kr_re_reg[PROD_W-1:FRAC_BITS]));
        n_im_next = NUM_W'($signed(p_rho_im_reg[PROD_W-1:FRAC_BITS]))
                  + NUM_W'($signed(p_kzjzre_reg[PROD_W-1:FRAC_BITS]))
                  + NUM_W'($signed(p_kr_im_reg[PROD_W-1:FRAC_BITS]));
        k2_next   = DEN_W'(kr2_reg) + DEN_W'(kz2_reg);
    end

    always_ff @(posedge clk)
    begin
        n_re_reg  <= n_re_next;
        n_im_reg  <= n_im_next;
        k2_reg    <= k2_next;
        side2_reg <= side1_reg;
    end

    assign out_valid = vld2_reg;
    assign n_re      = n_re_reg;
    assign n_im      = n_im_reg;
    assign k2        = k2_reg;
    assign side      = side2_reg;

endmodule
`default_nettype wire

[src/sccrz_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, for -n/k2
`default_nettype none
module sccrz_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic signed [sccrz_pkg::NUM_W-1:0] n_re,
    input  wire logic signed [sccrz_pkg::NUM_W-1:0] n_im,
    input  wire logic [sccrz_pkg::DEN_W-1:0]   k2,
    input  wire sccrz_pkg::side_t              in_side,
    output logic                               out_valid,
    output sccrz_pkg::data_t                   f_re,
    output sccrz_pkg::data_t                   f_im,
    output sccrz_pkg::side_t                   out_side
);
    import sccrz_pkg::*;

    logic [NUM_W-1:0] mag_re, mag_im;
    div_st_t          setup_next;
    div_st_t          st_next [1:Q_BITS];
    div_st_t          st_reg  [0:Q_BITS];
    logic             vld_reg [0:Q_BITS];
    logic [DEN_W:0]   sh_re, sh_im;
    data_t            f_re_next, f_im_next, f_re_reg, f_im_reg;
    side_t            side_reg;
    logic             vld_out_reg;
    div_st_t          last;

    always_comb
    begin
        mag_re = n_re[NUM_W-1] ? NUM_W'(-n_re) : NUM_W'(n_re);
        mag_im = n_im[NUM_W-1] ? NUM_W'(-n_im) : NUM_W'(n_im);
        setup_next.r_re   = DEN_W'(mag_re);
        setup_next.r_im   = DEN_W'(mag_im);
        setup_next.q_re   = '0;
        setup_next.q_im   = '0;
        setup_next.neg_re = (n_re > 0);
        setup_next.neg_im = (n_im > 0);
        // quotient would not fit: clamp
        setup_next.ovf_re = (DEN_W'({mag_re, 1'b0}) >= k2);
        setup_next.ovf_im = (DEN_W'({mag_im, 1'b0}) >= k2);
        setup_next.d      = k2;
        setup_next.side   = in_side;
    end

    always_comb
    begin
        for (int k = 1; k <= Q_BITS; k++)
        begin
            st_next[k] = st_reg[k-1];
            sh_re = {st_reg[k-1].r_re, 1'b0};
            sh_im = {st_reg[k-1].r_im, 1'b0};
            if (sh_re >= {1'b0, st_reg[k-1].d})
            begin
                st_next[k].r_re = DEN_W'(sh_re - {1'b0, st_reg[k-1].d});
                st_next[k].q_re = {st_reg[k-1].q_re[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                st_next[k].r_re = sh_re[DEN_W-1:0];
                st_next[k].q_re = {st_reg[k-1].q_re[Q_BITS-2:0], 1'b0};
            end
            if (sh_im >= {1'b0, st_reg[k-1].d})
            begin
                st_next[k].r_im = DEN_W'(sh_im - {1'b0, st_reg[k-1].d});
                st_next[k].q_im = {st_reg[k-1].q_im[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                st_next[k].r_im = sh_im[DEN_W-1:0];
                st_next[k].q_im = {st_reg[k-1].q_im[Q_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Q_BITS; k++)
                vld_reg[k] <= 1'b0;
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= Q_BITS; k++)
                vld_reg[k] <= vld_reg[k-1];
            vld_out_reg <= vld_reg[Q_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= setup_next;
        for (int k = 1; k <= Q_BITS; k++)
            st_reg[k] <= st_next[k];
    end

    always_comb
    begin
        last = st_reg[Q_BITS];
        if (last.ovf_re)
            f_re_next = last.neg_re ? DATA_MIN : DATA_MAX;
        else
            f_re_next = last.neg_re ? -$signed(last.q_re) : $signed(last.q_re);
        if (last.ovf_im)
            f_im_next = last.neg_im ? DATA_MIN : DATA_MAX;
        else
            f_im_next = last.neg_im ? -$signed(last.q_im) : $signed(last.q_im);
    end

    always_ff @(posedge clk)
    begin
        f_re_reg <= f_re_next;
        f_im_reg <= f_im_next;
        side_reg <= last.side;
    end

    assign out_valid = vld_out_reg;
    assign f_re      = f_re_reg;
    assign f_im      = f_im_reg;
    assign out_side  = side_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> ##(Q_BITS) vld_reg[Q_BITS])
        else $error("divider valid lost in pipeline");
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[Q_BITS] && !last.ovf_re && !last.side.zero_k |-> !last.q_re[Q_BITS-1])
        else $error("quotient exceeds range without overflow flag");

endmodule
`default_nettype wire

[src/sccrz_update.sv]
// Correction products, final sums with saturation and the zero-wavenumber bypass
`default_nettype none
module sccrz_update (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire sccrz_pkg::data_t  f_re,
    input  wire sccrz_pkg::data_t  f_im,
    input  wire sccrz_pkg::side_t  in_side,
    output logic                   out_valid,
    output sccrz_pkg::out_item_t   result
);
    import sccrz_pkg::*;

    logic signed [PROD_W-1:0] hp_re_reg, hp_im_reg, az_re_reg, az_im_reg;
    side_t                    side_reg;
    logic                     vld1_reg, vld2_reg;
    out_item_t                res_next, res_reg;
    logic signed [SUM_W-1:0]  h_re, h_im, a_re, a_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hp_re_reg <= PROD_W'(in_side.kr) * PROD_W'(f_re);
        hp_im_reg <= PROD_W'(in_side.kr) * PROD_W'(f_im);
        az_re_reg <= PROD_W'(in_side.kz) * PROD_W'(f_im);
        az_im_reg <= PROD_W'(in_side.kz) * PROD_W'(f_re);
        side_reg  <= in_side;
    end

    always_comb
    begin
        // half term drops one more bit than the axial term
        h_re = SUM_W'($signed(hp_re_reg[PROD_W-1:FRAC_BITS+1]));
        h_im = SUM_W'($signed(hp_im_reg[PROD_W-1:FRAC_BITS+1]));
        a_re = SUM_W'($signed(az_re_reg[PROD_W-1:FRAC_BITS]));
        a_im = SUM_W'($signed(az_im_reg[PROD_W-1:FRAC_BITS]));
        if (side_reg.zero_k)
        begin
            res_next.out_jplus_re  = side_reg.jp_re;
            res_next.out_jplus_im  = side_reg.jp_im;
            res_next.out_jminus_re = side_reg.jm_re;
            res_next.out_jminus_im = side_reg.jm_im;
            res_next.out_jaxial_re = side_reg.jz_re;
            res_next.out_jaxial_im = side_reg.jz_im;
        end
        else
        begin
            res_next.out_jplus_re  = sat_data(SUM_W'(side_reg.jp_re) + h_re);
            res_next.out_jplus_im  = sat_data(SUM_W'(side_reg.jp_im) + h_im);
            res_next.out_jminus_re = sat_data(SUM_W'(side_reg.jm_re) - h_re);
            res_next.out_jminus_im = sat_data(SUM_W'(side_reg.jm_im) - h_im);
            res_next.out_jaxial_re = sat_data(SUM_W'(side_reg.jz_re) + a_re);
            res_next.out_jaxial_im = sat_data(SUM_W'(side_reg.jz_im) - a_im);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = vld2_reg;
    assign result    = res_reg;

endmodule
`default_nettype wire

[src/spectral_current_correction_rz_top.sv]
// Top level of the RZ spectral current correction pipeline
//
//  channel   signals                          direction  transfer
//  command   start, busy, item                in         start && !busy
//  result    result_valid, result             out        result_valid, one cycle
//  config    cfg_valid, cfg_ready, cfg_data   in         cfg_valid && cfg_ready
//
// One word enters per cycle; busy stays low. Each command passes through two
// numerator stages, one divider setup stage, 32 quotient-bit stages, one
// quotient clamp stage and two update stages before its result appears.
// Reset clears all valid bits and loads 1.0 into the inverse time step.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module spectral_current_correction_rz_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire sccrz_pkg::in_item_t         item,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [sccrz_pkg::INV_W-1:0] cfg_data,
    output logic                             result_valid,
    output sccrz_pkg::out_item_t             result
);
    import sccrz_pkg::*;

    logic [INV_W-1:0]        inv_dt_reg;
    logic                    num_valid, div_valid;
    logic signed [NUM_W-1:0] n_re, n_im;
    logic [DEN_W-1:0]        k2;
    side_t                   num_side, div_side;
    data_t                   f_re, f_im;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_dt_reg <= INV_RESET;
        else if (cfg_valid && cfg_ready)
            inv_dt_reg <= cfg_data;
    end

    sccrz_numer u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_item   (item),
        .inv_dt    (inv_dt_reg),
        .out_valid (num_valid),
        .n_re      (n_re),
        .n_im      (n_im),
        .k2        (k2),
        .side      (num_side)
    );

    sccrz_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_valid),
        .n_re      (n_re),
        .n_im      (n_im),
        .k2        (k2),
        .in_side   (num_side),
        .out_valid (div_valid),
        .f_re      (f_re),
        .f_im      (f_im),
        .out_side  (div_side)
    );

    sccrz_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .f_re      (f_re),
        .f_im      (f_im),
        .in_side   (div_side),
        .out_valid (result_valid),
        .result    (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(LATENCY) result_valid)
        else $error("command word produced no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##(LATENCY) !result_valid)
        else $error("result word without command");
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $past(item.radial_wavenumber == '0 &&
                              item.axial_wavenumber == '0, LATENCY)
        |-> result.out_jplus_re == $past(item.jplus_re, LATENCY) &&
            result.out_jaxial_im == $past(item.jaxial_im, LATENCY))
        else $error("zero wavenumber bypass altered currents");

endmodule
`default_nettype wire
